// ===== rtl/csvp_pkg.sv =====
package csvp_pkg;

   // Signed range of a converted argument. The magnitude register needs one
   // bit more than the positive range so it can hold the negative limit.
   localparam int VALUE_BITS = 32;
   localparam int MAG_BITS = VALUE_BITS;
   localparam int VALUE_WIDTH = 32;
   localparam int RES_BITS = (VALUE_BITS > VALUE_WIDTH) ? VALUE_BITS : VALUE_WIDTH;

   localparam logic [MAG_BITS-1:0] MAG_CAP = {1'b1, {(MAG_BITS-1){1'b0}}};
   localparam logic [MAG_BITS-1:0] MAG_MAX = {1'b0, {(MAG_BITS-1){1'b1}}};

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [1:0] KIND_NAME_CHAR = 2'd0;
   localparam logic [1:0] KIND_NAME_END = 2'd1;
   localparam logic [1:0] KIND_ARGUMENT = 2'd2;

   typedef enum logic [4:0] {
      STAGE_SKIP   = 5'b00001,
      STAGE_SIGN   = 5'b00010,
      STAGE_DIGITS = 5'b00100,
      STAGE_DONE   = 5'b01000,
      STAGE_BAD    = 5'b10000
   } csvp_stage_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       message_end;
   } csvp_req_type;

   typedef struct packed {
      logic [1:0]                    kind;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          arg_valid;
      logic                          final_of_message;
      logic                          final_of_run;
   } csvp_rsp_type;

   // Results produced by one byte, handed from the parser to the queue.
   typedef struct packed {
      logic [1:0]   count;
      csvp_rsp_type first;
      csvp_rsp_type second;
   } csvp_push_type;

   // Builds the argument result for a token in the given parse state.
   function automatic csvp_rsp_type arg_result(csvp_stage_type stage, logic neg,
                                               logic [MAG_BITS-1:0] mag,
                                               logic fmsg);
      csvp_rsp_type        res;
      logic                ok;
      logic [RES_BITS-1:0] wide;
      ok = (stage == STAGE_DIGITS) || (stage == STAGE_DONE);
      if (!ok) begin
         wide = '0;
      end else if (neg) begin
         wide = RES_BITS'(0) - RES_BITS'(mag);
      end else if (mag[MAG_BITS-1]) begin
         wide = RES_BITS'(MAG_MAX);
      end else begin
         wide = RES_BITS'(mag);
      end
      res.kind = KIND_ARGUMENT;
      res.value = wide[VALUE_WIDTH-1:0];
      res.arg_valid = ok;
      res.final_of_message = fmsg;
      res.final_of_run = 1'b1;
      return res;
   endfunction

   function automatic csvp_rsp_type name_end_result(logic fmsg);
      csvp_rsp_type res;
      res.kind = KIND_NAME_END;
      res.value = '0;
      res.arg_valid = 1'b0;
      res.final_of_message = fmsg;
      res.final_of_run = 1'b1;
      return res;
   endfunction

endpackage

// ===== rtl/csv_decimal_field_parser_unit.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_data  (char_in, message_end)
// rsp_      out        rsp_valid/rsp_ready  rsp_data  (kind, value, arg_valid,
//                                                      final_of_message, final_of_run)
//
// One byte is accepted per cycle while the result queue has room. A byte
// that ends a message while the name is still being read makes two results;
// the result port drains one per cycle while rsp_ready is high. Each result
// passes through the input register, then the result queue, before it is
// presented on the result port.
// Reset returns the parser to reading a command name.
// A stalled result port fills the four-entry result queue; the input stops
// once fewer than two entries are free, and no byte is ever dropped.
module csv_decimal_field_parser_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  csvp_pkg::csvp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output csvp_pkg::csvp_rsp_type rsp_data
);
   import csvp_pkg::*;

   // The input register holds one byte. It hands the byte to the parser when
   // the result queue can take every result that byte may cause, and it can
   // refill in the same cycle, so bytes stream at one per clock while the queue has room.
   logic          s1_valid_ff, s1_valid_in;
   csvp_req_type  s1_req_ff;
   logic          room;
   logic          advance;
   csvp_push_type push;

   assign advance = s1_valid_ff && room;
   // Ready depends only on registered state, never on rsp_ready directly.
   assign req_ready = !s1_valid_ff || room;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // The parser keeps the name/argument mode and the token state, and turns
   // each byte into zero, one or two results in a single pass.
   csvp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (s1_req_ff),
      .push    (push)
   );

   // Results are written into a short queue that serves as the output
   // register; it decouples the parser from stalls on the result port.
   csvp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The last byte of a message always closes something: a name or a token.
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_req_ff.message_end) |-> (push.count != 2'd0))
      else $error("message end produced no result");

   // Two results only come from a name byte that ends the message.
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> ((push.first.kind == KIND_NAME_CHAR) &&
                                (push.second.kind == KIND_NAME_END) &&
                                push.second.final_of_message))
      else $error("unexpected result pair");

   // The last result of a message is also the last result of its byte.
   assert property (@(posedge clock) disable iff (reset)
      ((push.count == 2'd1) && push.first.final_of_message) |-> push.first.final_of_run)
      else $error("message end not marked as end of run");

   // Nothing is handed to the queue without a byte moving out of the input register.
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> advance)
      else $error("results pushed without a byte");

endmodule

// ===== rtl/csvp_parse.sv =====
module csvp_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  csvp_pkg::csvp_req_type  req,
   output csvp_pkg::csvp_push_type push
);
   import csvp_pkg::*;

   logic                in_args_ff, in_args_in;
   csvp_stage_type      stage_ff, stage_in;
   logic                neg_ff, neg_in;
   logic [MAG_BITS-1:0] mag_ff, mag_in;

   logic                is_comma, is_blank, is_digit, is_sign, last;
   logic [3:0]          digit;
   logic [MAG_BITS+3:0] acc_trial;
   logic [MAG_BITS-1:0] acc_mag;
   csvp_stage_type      fed_stage;
   logic                fed_neg;
   logic [MAG_BITS-1:0] fed_mag;
   logic [1:0]          count;

   assign last = req.message_end;
   assign is_comma = req.char_in == CHAR_COMMA;
   assign is_blank = (req.char_in == CHAR_SPACE) ||
                     ((req.char_in >= CHAR_TAB) && (req.char_in <= CHAR_CR));
   assign is_digit = (req.char_in >= CHAR_DIGIT_0) && (req.char_in <= CHAR_DIGIT_9);
   assign is_sign = (req.char_in == CHAR_PLUS) || (req.char_in == CHAR_MINUS);
   assign digit = 4'(req.char_in - CHAR_DIGIT_0);

   // Multiply by ten as two shifts and an add; anything past the cap clamps.
   assign acc_trial = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + (MAG_BITS+4)'(digit);
   assign acc_mag = (acc_trial > (MAG_BITS+4)'(MAG_CAP)) ? MAG_CAP : acc_trial[MAG_BITS-1:0];

   always_comb begin
      fed_stage = stage_ff;
      fed_neg = neg_ff;
      fed_mag = mag_ff;
      unique case (stage_ff)
         STAGE_SKIP: begin
            if (is_blank) begin
               fed_stage = STAGE_SKIP;
            end else if (is_sign) begin
               fed_neg = req.char_in == CHAR_MINUS;
               fed_stage = STAGE_SIGN;
            end else if (is_digit) begin
               fed_mag = acc_mag;
               fed_stage = STAGE_DIGITS;
            end else begin
               fed_stage = STAGE_BAD;
            end
         end
         STAGE_SIGN: begin
            if (is_digit) begin
               fed_mag = acc_mag;
               fed_stage = STAGE_DIGITS;
            end else begin
               fed_stage = STAGE_BAD;
            end
         end
         STAGE_DIGITS: begin
            if (is_digit) begin
               fed_mag = acc_mag;
            end else if (req.char_in == CHAR_NUL) begin
               fed_stage = STAGE_DONE;
            end else begin
               fed_stage = STAGE_BAD;
            end
         end
         STAGE_DONE: fed_stage = STAGE_DONE;
         STAGE_BAD:  fed_stage = STAGE_BAD;
         default:    fed_stage = STAGE_BAD;
      endcase
   end

   always_comb begin
      in_args_in = in_args_ff;
      stage_in = stage_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      count = 2'd0;
      push.first = '0;
      push.second = '0;
      if (!in_args_ff) begin
         if (is_comma) begin
            push.first = name_end_result(last);
            count = 2'd1;
            in_args_in = 1'b1;
         end else begin
            push.first.kind = KIND_NAME_CHAR;
            push.first.value = VALUE_WIDTH'(req.char_in);
            push.first.final_of_run = !last;
            count = 2'd1;
            if (last) begin
               push.second = name_end_result(1'b1);
               count = 2'd2;
            end
         end
      end else if (is_comma) begin
         push.first = arg_result(stage_ff, neg_ff, mag_ff, last);
         count = 2'd1;
         stage_in = STAGE_SKIP;
         neg_in = 1'b0;
         mag_in = '0;
      end else begin
         stage_in = fed_stage;
         neg_in = fed_neg;
         mag_in = fed_mag;
         if (last) begin
            push.first = arg_result(fed_stage, fed_neg, fed_mag, 1'b1);
            count = 2'd1;
         end
      end
      if (last) begin
         in_args_in = 1'b0;
         stage_in = STAGE_SKIP;
         neg_in = 1'b0;
         mag_in = '0;
      end
      push.count = advance ? count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_args_ff <= 1'b0;
         stage_ff <= STAGE_SKIP;
         neg_ff <= 1'b0;
         mag_ff <= '0;
      end else if (advance) begin
         in_args_ff <= in_args_in;
         stage_ff <= stage_in;
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

endmodule

// ===== rtl/csvp_rsp_fifo.sv =====
module csvp_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  csvp_pkg::csvp_push_type push,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output csvp_pkg::csvp_rsp_type  rsp_data
);
   import csvp_pkg::*;

   csvp_rsp_type            mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ff, wr_in;
   logic [RSP_PTR_BITS-1:0] rd_ff, rd_in;
   logic [RSP_PTR_BITS:0]   count_ff, count_in;
   logic                    pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data = mem_ff[rd_ff];
   assign pop = rsp_valid && rsp_ready;
   // Room for the largest burst one byte can cause.
   assign room = count_ff <= (RSP_PTR_BITS+1)'(RSP_DEPTH - 2);

   assign wr_in = wr_ff + RSP_PTR_BITS'(push.count);
   assign rd_in = rd_ff + RSP_PTR_BITS'(pop);
   assign count_in = count_ff + (RSP_PTR_BITS+1)'(push.count) - (RSP_PTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + RSP_PTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
